[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks, compiled out for synthesis
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/dsw_pkg.sv]
`timescale 1ns / 1ps

package dsw_pkg;

   localparam int unsigned FIELD_W = 14;

   localparam logic [FIELD_W-1:0] ACC_MAX    = 14'd9999;
   localparam logic [FIELD_W-1:0] YEAR_LIMIT = 14'd100;
   localparam logic [FIELD_W-1:0] YEAR_BASE  = 14'd2000;
   localparam logic [FIELD_W-1:0] MONTH_MAX  = 14'd12;
   localparam logic [FIELD_W-1:0] WEEK_BIAS  = 14'd35;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;

   // reciprocals for division by constants
   localparam logic [12:0] RECIP_100 = 13'd5243;  // year / 100 = (year * 5243) >> 19
   localparam logic [5:0]  RECIP_12  = 6'd43;     // yc / 12 = (yc * 43) >> 9
   localparam logic [13:0] RECIP_7   = 14'd9363;  // s / 7 = (s * 9363) >> 16

   typedef enum logic [1:0] {
      FIELD_YEAR  = 2'd0,
      FIELD_MONTH = 2'd1,
      FIELD_DAY   = 2'd2
   } field_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [2:0]         weekday;
      logic               date_valid;
      logic [FIELD_W-1:0] year_value;
      logic [FIELD_W-1:0] month_value;
      logic [FIELD_W-1:0] day_value;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
   } date_type;

   typedef struct packed {
      logic     empty;
      date_type data;
   } queue_out_type;

   function automatic logic [4:0] month_anchor(input logic [3:0] month);
      logic [4:0] ma;
      case (month)
         4'd1:    ma = 5'd3;
         4'd2:    ma = 5'd28;
         4'd3:    ma = 5'd14;
         4'd4:    ma = 5'd4;
         4'd5:    ma = 5'd9;
         4'd6:    ma = 5'd6;
         4'd7:    ma = 5'd11;
         4'd8:    ma = 5'd8;
         4'd9:    ma = 5'd5;
         4'd10:   ma = 5'd10;
         4'd11:   ma = 5'd7;
         4'd12:   ma = 5'd12;
         default: ma = 5'd0;
      endcase
      return ma;
   endfunction

   function automatic logic [2:0] century_anchor(input logic [1:0] cmod4);
      logic [2:0] a;
      case (cmod4)
         2'd0:    a = 3'd2;
         2'd1:    a = 3'd0;
         2'd2:    a = 3'd5;
         default: a = 3'd3;
      endcase
      return a;
   endfunction

   // value below 28 reduced into 0..6
   function automatic logic [2:0] mod7_small(input logic [4:0] v);
      logic [4:0] r;
      if (v >= 5'd21) begin
         r = v - 5'd21;
      end else if (v >= 5'd14) begin
         r = v - 5'd14;
      end else if (v >= 5'd7) begin
         r = v - 5'd7;
      end else begin
         r = v;
      end
      return r[2:0];
   endfunction

endpackage

[src/date_string_weekday_doomsday.sv]
`timescale 1ns / 1ps

// one char per cycle unless full; full rises only while the date queue holds QUEUE_DEPTH dates
// on the last character the date is queued, then passes stages 1 to 3 and the result register
// throughput: one date result per cycle from the four-stage weekday pipeline while pop drains it
// reset: synchronous active high, clears parse state, queue pointers and pipeline valids

module date_string_weekday_doomsday
   import dsw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic          accept;
   logic          date_push;
   date_type      date_front;
   logic          queue_pop;
   queue_out_type queue_out;

   assign accept = push && !full;

   dsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .date_push (date_push),
      .date_out  (date_front)
   );

   dsw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (date_push),
      .data_in   (date_front),
      .full_out  (full),
      .pop_in    (queue_pop),
      .queue_out (queue_out)
   );

   dsw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_in  (queue_out),
      .queue_pop (queue_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

[src/dsw_front.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dsw_front
   import dsw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req_data,
   output logic     date_push,
   output date_type date_out
);

   logic [FIELD_W-1:0] acc_ff, acc_in;
   field_type          field_ff, field_in;
   logic [FIELD_W-1:0] year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;

   logic               is_digit;
   logic               is_sep;
   logic [17:0]        acc_next;

   assign is_digit = (req_data.char_code >= CHAR_ZERO) && (req_data.char_code <= CHAR_NINE);
   assign is_sep   = (req_data.char_code == CHAR_SLASH) || (req_data.char_code == CHAR_DASH);

   // acc * 10 + digit, the digit is the low nibble of its code
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {14'd0, req_data.char_code[3:0]};

   always_comb begin
      acc_in   = acc_ff;
      field_in = field_ff;
      year_in  = year_ff;
      month_in = month_ff;
      if (is_digit) begin
         acc_in = (acc_next > {4'd0, ACC_MAX}) ? ACC_MAX : acc_next[FIELD_W-1:0];
      end else if (is_sep) begin
         unique case (field_ff)
            FIELD_YEAR: begin
               year_in  = acc_ff;
               field_in = FIELD_MONTH;
            end
            FIELD_MONTH: begin
               month_in = acc_ff;
               field_in = FIELD_DAY;
            end
            default: begin
               field_in = field_ff;
            end
         endcase
         acc_in = '0;
      end
   end

   always_comb begin
      date_out.year  = (year_in < YEAR_LIMIT) ? year_in + YEAR_BASE : year_in;
      date_out.month = month_in;
      date_out.day   = acc_in;
   end

   assign date_push = accept && req_data.last_char;

   always_ff @(posedge clock) begin
      if (reset || date_push) begin
         acc_ff   <= '0;
         field_ff <= FIELD_YEAR;
         year_ff  <= '0;
         month_ff <= '0;
      end else if (accept) begin
         acc_ff   <= acc_in;
         field_ff <= field_in;
         year_ff  <= year_in;
         month_ff <= month_in;
      end
   end

   `ASSERT_ALWAYS(a_acc_saturated, clock, reset, acc_ff <= ACC_MAX, "accumulator above limit")

endmodule

[src/dsw_queue.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dsw_queue
   import dsw_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_in,
   input  date_type      data_in,
   output logic          full_out,
   input  logic          pop_in,
   output queue_out_type queue_out
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   date_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full_out        = (count_ff == CNT_W'(DEPTH));
   assign queue_out.empty = (count_ff == '0);
   assign queue_out.data  = mem_ff[rd_ptr_ff];

   assign do_push = push_in && !full_out;
   assign do_pop  = pop_in && !queue_out.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count overrun")
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop_in, !queue_out.empty, "pop from empty queue")

endmodule

[src/dsw_back.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dsw_back
   import dsw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type queue_in,
   output logic          queue_pop,
   output logic          empty,
   input  logic          pop,
   output rsp_type       rsp_data
);

   // stage 1: year times reciprocal of 100
   logic               v1_ff;
   date_type           date1_ff;
   logic [25:0]        prod1_ff;
   // stage 2: century, year in century, leap
   logic               v2_ff;
   date_type           date2_ff;
   logic [6:0]         yc2_ff;
   logic [2:0]         anchor2_ff;
   logic               leap2_ff;
   // stage 3: doomsday and biased weekday sum
   logic               v3_ff;
   date_type           date3_ff;
   logic               valid3_ff;
   logic [FIELD_W-1:0] sum3_ff;
   // result register
   logic               out_v_ff;
   rsp_type            out_ff;

   logic en_out, en3, en2, en1;

   assign en_out    = !out_v_ff || pop;
   assign en3       = !v3_ff || en_out;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign queue_pop = en1 && !queue_in.empty;

   // stage 1 logic
   logic [25:0]        prod1_in;

   assign prod1_in = queue_in.data.year * RECIP_100;

   // stage 2 logic
   logic [6:0]         century;
   logic [FIELD_W-1:0] c100;
   logic [FIELD_W-1:0] yc_full;
   logic [6:0]         yc_in;
   logic               leap_in;

   assign century = prod1_ff[25:19];
   assign c100    = {1'b0, century, 6'd0} + {2'b0, century, 5'd0} + {5'b0, century, 2'd0};
   assign yc_full = date1_ff.year - c100;
   assign yc_in   = yc_full[6:0];
   assign leap_in = (date1_ff.year[1:0] == 2'b00) && ((yc_in != 7'd0) || (century[1:0] == 2'b00));

   // stage 3 logic
   logic [12:0]        p12;
   logic [3:0]         q12;
   logic [6:0]         r12_full;
   logic [3:0]         r12;
   logic [4:0]         dd_raw;
   logic [2:0]         dd;
   logic               valid_in;
   logic [4:0]         ma;
   logic [FIELD_W-1:0] sum_in;

   assign p12      = yc2_ff * RECIP_12;
   assign q12      = p12[12:9];
   // remainder: yc - 12 * q, with 12 * q as q * 8 + q * 4
   assign r12_full = yc2_ff - ({q12, 3'b000} + {1'b0, q12, 2'b00});
   assign r12      = r12_full[3:0];
   assign dd_raw   = {2'b00, anchor2_ff} + {1'b0, q12} + {1'b0, r12} + {3'b000, r12[3:2]};
   assign dd       = mod7_small(dd_raw);
   assign valid_in = (date2_ff.month >= 14'd1) && (date2_ff.month <= MONTH_MAX);
   assign ma       = month_anchor(date2_ff.month[3:0])
                   + {4'd0, leap2_ff && (date2_ff.month <= 14'd2)};
   assign sum_in   = date2_ff.day + {11'd0, dd} + WEEK_BIAS - {9'd0, ma};

   // result logic: sum mod 7
   logic [27:0]        p7;
   logic [10:0]        q7;
   logic [FIELD_W-1:0] wd_full;

   assign p7      = sum3_ff * RECIP_7;
   assign q7      = p7[26:16];
   assign wd_full = sum3_ff - ({q7, 3'b000} - {3'b000, q7});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= !queue_in.empty;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en_out) out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         date1_ff <= queue_in.data;
         prod1_ff <= prod1_in;
      end
      if (en2) begin
         date2_ff   <= date1_ff;
         yc2_ff     <= yc_in;
         anchor2_ff <= century_anchor(century[1:0]);
         leap2_ff   <= leap_in;
      end
      if (en3) begin
         date3_ff  <= date2_ff;
         valid3_ff <= valid_in;
         sum3_ff   <= sum_in;
      end
      if (en_out) begin
         out_ff.weekday     <= valid3_ff ? wd_full[2:0] : 3'd0;
         out_ff.date_valid  <= valid3_ff;
         out_ff.year_value  <= date3_ff.year;
         out_ff.month_value <= date3_ff.month;
         out_ff.day_value   <= date3_ff.day;
      end
   end

   assign empty    = !out_v_ff;
   assign rsp_data = out_ff;

   `ASSERT_IMPLIES(a_invalid_sunday, clock, reset, out_v_ff && !out_ff.date_valid, out_ff.weekday == 3'd0, "invalid date with weekday")
   `ASSERT_NEXT(a_stage3_held, clock, reset, v3_ff && !en3, v3_ff, "stalled stage dropped")

endmodule
